FILE: hdl/gtsa_pkg.sv
package gtsa_pkg;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_REF   = 2'd1;
  localparam logic [1:0] ACT_UNREF = 2'd2;
  localparam logic [1:0] ACT_TRY   = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_STALE  = 3'd2;
  localparam logic [2:0] ST_BADIDX = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [10:0] slot_num;
    logic [15:0] handle_gen;
  } gtsa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] granted_index;
    logic [15:0] slot_gen;
    logic [7:0]  ref_count;
    logic        retired;
  } gtsa_rsp_t;

endpackage

FILE: hdl/gtsa_ram.sv
module gtsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/generation_tagged_slot_allocator_top.sv
// Generation-tagged slot allocator. Each request is handled in order: first the slot
// entry (generation and count) and the free-list link are read from their memories, then,
// once any earlier result has been taken, they are updated and written back and the result
// register is loaded. A new request is taken as soon as the previous one has written back,
// even while its result still waits on out_ready. Slots are numbered 1 to SLOTS; slot 0 is
// never granted. Entries at or above the next never-used slot number read as generation 0,
// count 0, so reset needs no clearing pass and the block takes requests from the first
// cycle after reset.
module generation_tagged_slot_allocator_top import gtsa_pkg::*; #(
  parameter int SLOTS      = 1024,
  parameter int GEN_BITS   = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gtsa_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output gtsa_rsp_t out_data
);

  localparam int AW   = $clog2(SLOTS);
  localparam int SN_W = $clog2(SLOTS + 2);
  localparam int EW   = GEN_BITS + COUNT_BITS;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic            state_r, state_nxt;
  gtsa_req_t       req_r;
  logic [SN_W-1:0] free_head_r, free_head_nxt;
  logic [SN_W-1:0] next_fresh_r, next_fresh_nxt;
  logic            out_valid_r, out_valid_nxt;
  gtsa_rsp_t       out_data_r;

  logic            accept;
  logic            fire;
  logic [31:0]     in_idx32;
  logic [AW-1:0]   rd_addr;

  logic [EW-1:0]   ent_rd;
  logic [SN_W-1:0] link_rd;
  logic            ent_we, link_we;
  logic [AW-1:0]   ent_waddr, link_waddr;
  logic [EW-1:0]   ent_wdata;

  logic [31:0]           r_idx32;
  logic                  r_idx_ok;
  logic                  live;
  logic [GEN_BITS-1:0]   rd_gen, cur_gen, out_gen, gen_inc;
  logic [COUNT_BITS-1:0] rd_cnt, cur_cnt, out_cnt;
  logic [31:0]           gen_ext, cnt_ext;
  logic [SN_W-1:0]       got;
  logic                  full;
  gtsa_rsp_t             rsp;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // read address: head of free list for alloc, addressed slot otherwise
  assign in_idx32 = 32'(in_data.slot_num);
  assign rd_addr  = (in_data.action == ACT_ALLOC) ? AW'(32'(free_head_r) - 32'd1)
                                                  : AW'(in_idx32 - 32'd1);

  gtsa_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we && fire),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ent_rd)
  );

  gtsa_ram #(.WIDTH(SN_W), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we && fire),
    .waddr (link_waddr),
    .wdata (free_head_r),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  assign r_idx32  = 32'(req_r.slot_num);
  assign r_idx_ok = (r_idx32 != 32'd0) && (r_idx32 <= 32'(SLOTS));
  // entries at or above the fill count were never written
  assign live     = r_idx32 < 32'(next_fresh_r);
  assign rd_gen   = ent_rd[EW-1:COUNT_BITS];
  assign rd_cnt   = ent_rd[COUNT_BITS-1:0];
  assign cur_gen  = live ? rd_gen : '0;
  assign cur_cnt  = live ? rd_cnt : '0;
  assign gen_inc  = cur_gen + GEN_BITS'(1);
  assign gen_ext  = 32'(out_gen);
  assign cnt_ext  = 32'(out_cnt);

  always_comb begin
    rsp            = '0;
    out_gen        = '0;
    out_cnt        = '0;
    ent_we         = 1'b0;
    link_we        = 1'b0;
    ent_waddr      = AW'(r_idx32 - 32'd1);
    link_waddr     = AW'(r_idx32 - 32'd1);
    ent_wdata      = '0;
    free_head_nxt  = free_head_r;
    next_fresh_nxt = next_fresh_r;
    got            = '0;
    full           = 1'b0;
    if (req_r.action == ACT_ALLOC) begin
      if (free_head_r != '0) begin
        got           = free_head_r;
        out_gen       = rd_gen;
        free_head_nxt = link_rd;
      end else if (32'(next_fresh_r) <= 32'(SLOTS)) begin
        got            = next_fresh_r;
        next_fresh_nxt = next_fresh_r + SN_W'(1);
      end else begin
        full = 1'b1;
      end
      if (full) begin
        rsp.status = ST_FULL;
      end else begin
        out_cnt           = COUNT_BITS'(1);
        ent_we            = 1'b1;
        ent_waddr         = AW'(32'(got) - 32'd1);
        ent_wdata         = {out_gen, out_cnt};
        rsp.status        = ST_OK;
        rsp.granted_index = 11'(got);
      end
    end else if (!r_idx_ok) begin
      rsp.status        = ST_BADIDX;
      rsp.granted_index = req_r.slot_num;
    end else begin
      rsp.granted_index = req_r.slot_num;
      out_gen           = cur_gen;
      out_cnt           = cur_cnt;
      case (req_r.action)
        ACT_UNREF: begin
          if (cur_cnt == '0) begin
            rsp.status = ST_RANGE;
          end else if (cur_cnt == COUNT_BITS'(1)) begin
            out_gen       = gen_inc;
            out_cnt       = '0;
            ent_we        = 1'b1;
            ent_wdata     = {gen_inc, out_cnt};
            link_we       = 1'b1;
            free_head_nxt = SN_W'(r_idx32);
            rsp.status    = ST_OK;
            rsp.retired   = 1'b1;
          end else begin
            out_cnt    = cur_cnt - COUNT_BITS'(1);
            ent_we     = 1'b1;
            ent_wdata  = {cur_gen, out_cnt};
            rsp.status = ST_OK;
          end
        end
        default: begin
          // ref and try_ref
          if (cur_cnt == '0) begin
            rsp.status = ST_STALE;
          end else if ((req_r.action == ACT_TRY) &&
                       (32'(cur_gen) & 32'hFFFF) != 32'(req_r.handle_gen)) begin
            rsp.status = ST_STALE;
          end else if (cur_cnt == '1) begin
            rsp.status = ST_RANGE;
          end else begin
            out_cnt    = cur_cnt + COUNT_BITS'(1);
            ent_we     = 1'b1;
            ent_wdata  = {cur_gen, out_cnt};
            rsp.status = ST_OK;
          end
        end
      endcase
    end
    rsp.slot_gen  = gen_ext[15:0];
    rsp.ref_count = cnt_ext[7:0];
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      free_head_r  <= '0;
      next_fresh_r <= SN_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        free_head_r  <= free_head_nxt;
        next_fresh_r <= next_fresh_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (fire) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/gtsa_chk.sv
module gtsa_chk import gtsa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input gtsa_rsp_t out_data
);

  // one request in flight: ready drops right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in flight");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      out_data.granted_index == '0 && out_data.slot_gen == '0 &&
      out_data.ref_count == '0 && !out_data.retired)
    else $error("table full result carries nonzero fields");

  a_retired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.retired |->
      out_data.status == ST_OK && out_data.ref_count == '0)
    else $error("retired set without a clean release");

  a_ok_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |-> out_data.granted_index != '0)
    else $error("successful result names slot zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

endmodule

bind generation_tagged_slot_allocator_top gtsa_chk u_gtsa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: test/tb_generation_tagged_slot_allocator_top.sv
`timescale 1ns / 1ps

module tb_generation_tagged_slot_allocator_top;
  import gtsa_pkg::*;

  localparam int SLOTS        = 1024;
  localparam int COUNT_MAX    = 255;
  localparam int STALL_LIMIT  = 4000;
  localparam int MODEL_CHECK  = 0;
  localparam int MODEL_PLAN   = 1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  gtsa_req_t in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  gtsa_rsp_t out_data;

  generation_tagged_slot_allocator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // two copies of the slot table: one tracks accepted requests, one plans stimulus
  logic [15:0] gen_mem  [2][SLOTS+1];
  logic [7:0]  cnt_mem  [2][SLOTS+1];
  logic [10:0] link_mem [2][SLOTS+1];
  int unsigned head_slot  [2];
  int unsigned fresh_slot [2];

  gtsa_req_t pending_reqs[$];
  gtsa_rsp_t due_rsps[$];
  gtsa_rsp_t due_rsp;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        req_sent;
  int        req_taken;
  int        rsp_seen;
  int        fail_cnt;
  int        stall_cycles;

  function automatic gtsa_rsp_t slot_table_step(input int m, input gtsa_req_t r);
    gtsa_rsp_t   rsp;
    int unsigned s;
    rsp = '0;
    s = r.slot_num;
    if (r.action == ACT_ALLOC) begin
      if (head_slot[m] != 0) begin
        s = head_slot[m];
        head_slot[m] = link_mem[m][s];
      end else if (fresh_slot[m] <= SLOTS) begin
        s = fresh_slot[m];
        fresh_slot[m] = fresh_slot[m] + 1;
      end else begin
        rsp.status = ST_FULL;
        return rsp;
      end
      cnt_mem[m][s] = 8'd1;
      rsp.status = ST_OK;
      rsp.granted_index = 11'(s);
      rsp.slot_gen = gen_mem[m][s];
      rsp.ref_count = 8'd1;
      return rsp;
    end
    rsp.granted_index = r.slot_num;
    if (s == 0 || s > SLOTS) begin
      rsp.status = ST_BADIDX;
      return rsp;
    end
    rsp.slot_gen = gen_mem[m][s];
    rsp.ref_count = cnt_mem[m][s];
    if (r.action == ACT_UNREF) begin
      if (cnt_mem[m][s] == 0) begin
        rsp.status = ST_RANGE;
      end else begin
        cnt_mem[m][s] = cnt_mem[m][s] - 8'd1;
        rsp.status = ST_OK;
        rsp.ref_count = cnt_mem[m][s];
        if (cnt_mem[m][s] == 0) begin
          gen_mem[m][s] = gen_mem[m][s] + 16'd1;
          link_mem[m][s] = 11'(head_slot[m]);
          head_slot[m] = s;
          rsp.slot_gen = gen_mem[m][s];
          rsp.retired = 1'b1;
        end
      end
    end else begin
      if (cnt_mem[m][s] == 0 ||
          (r.action == ACT_TRY && gen_mem[m][s] != r.handle_gen)) begin
        rsp.status = ST_STALE;
      end else if (cnt_mem[m][s] == COUNT_MAX) begin
        rsp.status = ST_RANGE;
      end else begin
        cnt_mem[m][s] = cnt_mem[m][s] + 8'd1;
        rsp.status = ST_OK;
        rsp.ref_count = cnt_mem[m][s];
      end
    end
    return rsp;
  endfunction

  function automatic gtsa_rsp_t plan(input logic [1:0] act, input int idx, input int g);
    gtsa_req_t r;
    r.action = act;
    r.slot_num = 11'(idx);
    r.handle_gen = 16'(g);
    pending_reqs.push_back(r);
    return slot_table_step(MODEL_PLAN, r);
  endfunction

  function automatic int pick_live();
    int hi;
    int s;
    hi = int'(fresh_slot[MODEL_PLAN]) - 1;
    if (hi < 1) return 0;
    for (int k = 0; k < 16; k++) begin
      s = $urandom_range(1, hi);
      if (cnt_mem[MODEL_PLAN][s] != 0) return s;
    end
    return 0;
  endfunction

  function automatic void plan_random();
    int pick;
    int s;
    pick = $urandom_range(0, 99);
    s = pick_live();
    if (pick < 30 || (pick < 90 && s == 0)) begin
      void'(plan(ACT_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 65535)));
    end else if (pick < 50) begin
      void'(plan(ACT_REF, s, $urandom_range(0, 65535)));
    end else if (pick < 70) begin
      void'(plan(ACT_UNREF, s, $urandom_range(0, 65535)));
    end else if (pick < 85) begin
      void'(plan(ACT_TRY, s, gen_mem[MODEL_PLAN][s]));
    end else if (pick < 90) begin
      void'(plan(ACT_TRY, s, gen_mem[MODEL_PLAN][s] ^ 16'($urandom_range(1, 65535))));
    end else if (pick < 95) begin
      void'(plan(2'($urandom_range(0, 3)), $urandom_range(0, 2047), $urandom_range(0, 65535)));
    end else begin
      s = $urandom_range(1, SLOTS);
      void'(plan(2'($urandom_range(1, 3)), s, gen_mem[MODEL_PLAN][s]));
    end
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_sent != req_taken || due_rsps.size() != 0)
      @(posedge clk);
  endtask

  // request driver and result acceptor
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!(in_valid && req_sent != req_taken)) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_sent <= req_sent + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        rsp_seen++;
        if (due_rsps.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          fail_cnt++;
        end else begin
          due_rsp = due_rsps.pop_front();
          check_field("status", due_rsp.status, out_data.status);
          check_field("granted_index", due_rsp.granted_index, out_data.granted_index);
          check_field("slot_gen", due_rsp.slot_gen, out_data.slot_gen);
          check_field("ref_count", due_rsp.ref_count, out_data.ref_count);
          check_field("retired", due_rsp.retired, out_data.retired);
        end
      end
      if (in_valid && in_ready) begin
        due_rsps.push_back(slot_table_step(MODEL_CHECK, in_data));
        req_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("generation_tagged_slot_allocator_top regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    gtsa_rsp_t rsp;
    int        s;
    int        g;
    for (int m = 0; m < 2; m++) begin
      for (int i = 0; i <= SLOTS; i++) begin
        gen_mem[m][i] = '0;
        cnt_mem[m][i] = '0;
        link_mem[m][i] = '0;
      end
      head_slot[m] = 0;
      fresh_slot[m] = 1;
    end
    send_idle_pct = 34;
    recv_idle_pct = 51;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed requests
    void'(plan(ACT_ALLOC, 0, 0));
    void'(plan(ACT_ALLOC, 2047, 16'hFFFF));
    void'(plan(ACT_REF, 1, 0));
    void'(plan(ACT_TRY, 1, 0));
    void'(plan(ACT_TRY, 1, 16'hFFFF));
    void'(plan(ACT_TRY, 1, 16'h8000));
    void'(plan(ACT_UNREF, 1, 0));
    void'(plan(ACT_UNREF, 1, 0));
    void'(plan(ACT_UNREF, 1, 0));
    void'(plan(ACT_UNREF, 1, 0));
    void'(plan(ACT_REF, 1, 1));
    void'(plan(ACT_TRY, 1, 1));
    void'(plan(ACT_REF, 0, 0));
    void'(plan(ACT_UNREF, SLOTS + 1, 0));
    void'(plan(ACT_TRY, 2047, 16'hFFFF));
    void'(plan(ACT_REF, SLOTS, 0));
    void'(plan(ACT_UNREF, 2, 0));
    void'(plan(ACT_ALLOC, 0, 0));
    void'(plan(ACT_ALLOC, 0, 0));
    void'(plan(ACT_ALLOC, 0, 0));
    void'(plan(ACT_TRY, 2, 1));
    void'(plan(ACT_UNREF, 3, 0));
    for (int n = 0; n < 250; n++) plan_random();
    wait_drained();

    send_idle_pct = 51;
    recv_idle_pct = 34;
    for (int n = 0; n < 250; n++) plan_random();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // drive one slot into count saturation
    rsp = plan(ACT_ALLOC, 0, 0);
    s = rsp.granted_index;
    g = rsp.slot_gen;
    for (int n = 0; n < 256; n++) void'(plan((n % 3 == 0) ? ACT_TRY : ACT_REF, s, g));
    void'(plan(ACT_TRY, s, g));
    void'(plan(ACT_UNREF, s, 0));
    for (int n = 0; n < 170; n++) plan_random();
    wait_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d requests and %0d results over three pacing phases,", req_taken,
             rsp_seen);
    $display("including count saturation, stale handles, bad indices and slot reuse");
    if (fail_cnt == 0) begin
      $display("generation_tagged_slot_allocator_top regression: pass");
    end else begin
      $display("generation_tagged_slot_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
